// ----- rtl/cpts_pkg.sv -----
// Package for the counter-priority task scheduler.
// Task state codes, controller states and the command/status structs.
// No dependencies.
package cpts_pkg;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef enum logic [1:0] {
      TASK_READY    = 2'd0,
      TASK_RUNNING  = 2'd1,
      TASK_SLEEPING = 2'd2,
      TASK_BLOCKED  = 2'd3
   } task_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WRITE,
      ST_DEC_RD,
      ST_DEC_EVAL,
      ST_SCHED,
      ST_RDY_WR,
      ST_ZC,
      ST_ZC_CHK,
      ST_RL,
      ST_SEL,
      ST_SET_RUN,
      ST_RUN_RD,
      ST_RUN_WR,
      ST_OUT_RD,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_REQ,
      WR_READY,
      WR_DEC,
      WR_RUN
   } wr_sel_type;

   typedef enum logic [1:0] {
      SCAN_ZERO,
      SCAN_RELOAD,
      SCAN_SELECT
   } scan_mode_type;

   typedef struct packed {
      logic          capture;
      logic          rd_running;
      wr_sel_type    wr_sel;
      logic          scan_start;
      logic          scan_step;
      scan_mode_type scan_mode;
      logic          set_running;
      logic          load_rsp;
      logic          switched;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic running_valid;
      logic cnt_nonzero;
      logic all_zero;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/cpts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpts_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cpts_ctrl.sv -----
// Controller state machine of the task scheduler.
// Sequences ticks, writes and the three slot scans; depends on cpts_pkg.
module cpts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cpts_pkg::status_type status,
   output cpts_pkg::cmd_type    cmd
);
   import cpts_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           after_ff, after_in;
   logic           sw_ff, sw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= 1'b0;
         sw_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         sw_ff    <= sw_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      after_in        = after_ff;
      sw_in           = sw_ff;
      req_ready       = 1'b0;
      cmd.capture     = 1'b0;
      cmd.rd_running  = 1'b0;
      cmd.wr_sel      = WR_NONE;
      cmd.scan_start  = 1'b0;
      cmd.scan_step   = 1'b0;
      cmd.scan_mode   = SCAN_ZERO;
      cmd.set_running = 1'b0;
      cmd.load_rsp    = 1'b0;
      cmd.switched    = sw_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               sw_in       = 1'b0;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_write) begin
               state_in = ST_WRITE;
            end else if (status.running_valid) begin
               state_in = ST_DEC_RD;
            end else begin
               after_in = 1'b0;
               sw_in    = 1'b1;
               state_in = ST_SCHED;
            end
         end
         ST_WRITE: begin
            cmd.wr_sel = WR_REQ;
            state_in   = ST_OUT_RD;
         end
         ST_DEC_RD: begin
            cmd.rd_running = 1'b1;
            state_in       = ST_DEC_EVAL;
         end
         ST_DEC_EVAL: begin
            if (status.cnt_nonzero) begin
               cmd.wr_sel = WR_DEC;
               state_in   = ST_OUT_RD;
            end else begin
               after_in = 1'b1;
               sw_in    = 1'b1;
               state_in = ST_SCHED;
            end
         end
         ST_SCHED: begin
            if (status.running_valid) begin
               cmd.rd_running = 1'b1;
               state_in       = ST_RDY_WR;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_ZC;
            end
         end
         ST_RDY_WR: begin
            cmd.wr_sel     = WR_READY;
            cmd.scan_start = 1'b1;
            state_in       = ST_ZC;
         end
         ST_ZC: begin
            cmd.scan_step = 1'b1;
            cmd.scan_mode = SCAN_ZERO;
            if (status.scan_done) begin
               state_in = ST_ZC_CHK;
            end
         end
         ST_ZC_CHK: begin
            cmd.scan_start = 1'b1;
            state_in       = status.all_zero ? ST_RL : ST_SEL;
         end
         ST_RL: begin
            cmd.scan_step = 1'b1;
            cmd.scan_mode = SCAN_RELOAD;
            if (status.scan_done) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SEL;
            end
         end
         ST_SEL: begin
            cmd.scan_step = 1'b1;
            cmd.scan_mode = SCAN_SELECT;
            if (status.scan_done) begin
               state_in = ST_SET_RUN;
            end
         end
         ST_SET_RUN: begin
            cmd.set_running = 1'b1;
            state_in        = ST_RUN_RD;
         end
         ST_RUN_RD: begin
            cmd.rd_running = 1'b1;
            state_in       = ST_RUN_WR;
         end
         ST_RUN_WR: begin
            cmd.wr_sel = WR_RUN;
            state_in   = after_ff ? ST_OUT_RD : ST_DEC_RD;
         end
         ST_OUT_RD: begin
            cmd.rd_running = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/cpts_datapath.sv -----
// Datapath of the task scheduler: slot table RAM with valid bits, scan
// counter, selection registers and the result register.
// Depends on cpts_pkg and cpts_ram.
module cpts_datapath #(
   parameter int NUM_SLOTS  = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpts_pkg::cmd_type    cmd,
   output cpts_pkg::status_type status,
   input  logic                 req_type,
   input  logic [3:0]           req_slot,
   input  logic                 req_present,
   input  logic [1:0]           req_task_state_in,
   input  logic [7:0]           req_priority_in,
   input  logic [7:0]           req_counter_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_current_slot,
   output logic                 rsp_switched,
   output logic [7:0]           rsp_counter_left
);
   import cpts_pkg::*;

   localparam int AW       = $clog2(NUM_SLOTS);
   localparam int IW       = $clog2(NUM_SLOTS + 1);
   localparam int ENT_W    = 2 * COUNT_BITS + 3;
   localparam int CNT_LSB  = 0;
   localparam int PRI_LSB  = COUNT_BITS;
   localparam int ST_LSB   = 2 * COUNT_BITS;
   localparam int PRES_BIT = 2 * COUNT_BITS + 2;

   logic                  req_type_ff;
   logic [3:0]            slot_ff;
   logic                  present_ff;
   logic [1:0]            state_ff;
   logic [COUNT_BITS-1:0] prio_ff;
   logic [COUNT_BITS-1:0] cnt_ff;

   logic [AW-1:0]         running_slot_ff;
   logic                  running_valid_ff;
   logic [IW-1:0]         idx_ff;
   logic                  pipe_ff;
   logic [AW-1:0]         proc_ff;
   logic                  all_zero_ff;
   logic                  found_ff;
   logic [AW-1:0]         best_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [NUM_SLOTS-1:0]  valid_ff;
   logic                  rd_valid_ff;

   logic                  rsp_valid_ff;
   logic [3:0]            rsp_slot_ff;
   logic                  rsp_sw_ff;
   logic [7:0]            rsp_cnt_ff;

   logic [ENT_W-1:0]      rd_data;
   logic [ENT_W-1:0]      ent;
   logic                  ent_present;
   task_state_type        ent_state;
   task_state_type        keep_state;
   logic [COUNT_BITS-1:0] ent_prio;
   logic [COUNT_BITS-1:0] ent_cnt;
   logic                  issuing;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENT_W-1:0]      wr_data;
   logic                  slot_in_range;
   logic                  reload_hit;
   logic                  sel_hit;

   assign ent         = rd_valid_ff ? rd_data : '0;
   assign ent_present = ent[PRES_BIT];
   assign ent_state   = task_state_type'(ent[ST_LSB +: 2]);
   assign ent_prio    = ent[PRI_LSB +: COUNT_BITS];
   assign ent_cnt     = ent[CNT_LSB +: COUNT_BITS];
   assign keep_state  = (ent_state == TASK_SLEEPING || ent_state == TASK_BLOCKED) ?
                        ent_state : TASK_READY;

   assign issuing       = idx_ff != IW'(NUM_SLOTS);
   assign rd_en         = cmd.rd_running || (cmd.scan_step && issuing);
   assign rd_addr       = cmd.rd_running ? running_slot_ff : idx_ff[AW-1:0];
   assign slot_in_range = int'(slot_ff) < NUM_SLOTS;

   assign reload_hit = cmd.scan_step && cmd.scan_mode == SCAN_RELOAD && pipe_ff &&
                       ent_present;
   assign sel_hit    = cmd.scan_step && cmd.scan_mode == SCAN_SELECT && pipe_ff &&
                       ent_present && ent_state == TASK_READY &&
                       (!found_ff || ent_cnt > best_cnt_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = running_slot_ff;
      wr_data = ent;
      if (reload_hit) begin
         wr_en   = 1'b1;
         wr_addr = proc_ff;
         wr_data = {ent_present, ent_state, ent_prio, ent_prio};
      end else begin
         case (cmd.wr_sel)
            WR_REQ: begin
               wr_en   = slot_in_range;
               wr_addr = AW'(slot_ff);
               wr_data = {present_ff, state_ff, prio_ff, cnt_ff};
            end
            WR_READY: begin
               wr_en   = 1'b1;
               wr_data = {ent_present, keep_state, ent_prio, ent_cnt};
            end
            WR_DEC: begin
               wr_en   = 1'b1;
               wr_data = {ent_present, ent_state, ent_prio, ent_cnt - COUNT_BITS'(1)};
            end
            WR_RUN: begin
               wr_en   = 1'b1;
               wr_data = {ent_present, TASK_RUNNING, ent_prio, ent_cnt};
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   cpts_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         slot_ff     <= req_slot;
         present_ff  <= req_present;
         state_ff    <= req_task_state_in;
         prio_ff     <= COUNT_BITS'(req_priority_in);
         cnt_ff      <= COUNT_BITS'(req_counter_in);
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.scan_step) begin
         proc_ff <= idx_ff[AW-1:0];
      end
      if (cmd.scan_start) begin
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end else if (sel_hit) begin
         best_ff     <= proc_ff;
         best_cnt_ff <= ent_cnt;
      end
      if (cmd.load_rsp) begin
         rsp_slot_ff <= 4'(running_slot_ff);
         rsp_sw_ff   <= cmd.switched;
         rsp_cnt_ff  <= running_valid_ff ? 8'(ent_cnt) : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_slot_ff  <= '0;
         running_valid_ff <= 1'b0;
         idx_ff           <= IW'(NUM_SLOTS);
         pipe_ff          <= 1'b0;
         all_zero_ff      <= 1'b1;
         found_ff         <= 1'b0;
         valid_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.set_running) begin
            running_slot_ff  <= found_ff ? best_ff : '0;
            running_valid_ff <= 1'b1;
         end
         if (cmd.scan_start) begin
            idx_ff      <= IW'(1);
            pipe_ff     <= 1'b0;
            all_zero_ff <= 1'b1;
            found_ff    <= 1'b0;
         end else if (cmd.scan_step) begin
            if (issuing) begin
               idx_ff <= idx_ff + IW'(1);
            end
            pipe_ff <= issuing;
            if (cmd.scan_mode == SCAN_ZERO && pipe_ff && ent_present &&
                ent_cnt != '0) begin
               all_zero_ff <= 1'b0;
            end
            if (sel_hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.is_write      = req_type_ff == REQ_WRITE;
   assign status.running_valid = running_valid_ff;
   assign status.cnt_nonzero   = ent_cnt != '0;
   assign status.all_zero      = all_zero_ff;
   assign status.scan_done     = pipe_ff && !issuing;
   assign status.rsp_free      = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_slot = rsp_slot_ff;
   assign rsp_switched     = rsp_sw_ff;
   assign rsp_counter_left = rsp_cnt_ff;

endmodule

// ----- rtl/counter_priority_task_scheduler.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_type, req_slot, req_present,
//                                            req_task_state_in, req_priority_in,
//                                            req_counter_in
// rsp      out        rsp_valid/rsp_ready    rsp_current_slot, rsp_switched,
//                                            rsp_counter_left
//
// One transaction at a time. Each scheduling pass of a tick runs up to three
// table scans (zero check, reload, selection) through the single read port of
// the slot RAM, one slot per cycle; the reload scan runs only when every
// present task's counter is zero.
// Synchronous active-high reset empties the table at once via per-slot valid
// bits. A result waiting on rsp_ready does not block acceptance of the next
// request; only loading the following result waits for the output register.
// Depends on cpts_pkg, cpts_ctrl, cpts_datapath, cpts_ram.
module counter_priority_task_scheduler #(
   parameter int NUM_SLOTS  = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [3:0] req_slot,
   input  logic       req_present,
   input  logic [1:0] req_task_state_in,
   input  logic [7:0] req_priority_in,
   input  logic [7:0] req_counter_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_current_slot,
   output logic       rsp_switched,
   output logic [7:0] rsp_counter_left
);
   import cpts_pkg::*;

   cmd_type    cmd;
   status_type status;

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpts_datapath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_present       (req_present),
      .req_task_state_in (req_task_state_in),
      .req_priority_in   (req_priority_in),
      .req_counter_in    (req_counter_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_slot  (rsp_current_slot),
      .rsp_switched      (rsp_switched),
      .rsp_counter_left  (rsp_counter_left)
   );

endmodule
